/* sv/hdr_tm_pkg.sv */
// Shared types, constants and gamma threshold builder for the HDR tone mapper.
`default_nettype none

package hdr_tm_pkg;

   localparam int GammaTableBitsDefault = 12;
   localparam int GammaBitsMax          = 16;
   localparam int ThreshW               = GammaBitsMax + 1;
   localparam int FracBits              = 16;
   localparam int DivSteps              = FracBits;
   localparam int GammaSteps            = 8;
   localparam int PipeDepth             = 2 + DivSteps + GammaSteps;
   localparam logic [23:0] ExposureReset = 24'h010000;
   localparam logic [7:0]  FullByte      = 8'hFF;

   typedef struct packed {
      logic signed [31:0] hdr_red;
      logic signed [31:0] hdr_green;
      logic signed [31:0] hdr_blue;
      logic               texel_valid;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic [7:0] mask_byte;
   } rsp_type;

   // One step of the Reinhard divider: partial remainder, divisor, quotient so far.
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dvs;
      logic [15:0] quo;
   } div_stage_type;

   typedef logic [255:0][ThreshW-1:0] thresh_table_type;
   typedef logic [191:0] big_type;

   function automatic big_type pow_big(big_type base, int unsigned n);
      big_type r;
      r = big_type'(1);
      for (int unsigned i = 0; i < n; i++) begin
         r = r * base;
      end
      return r;
   endfunction

   // Entry b is the smallest index t with b^11 * 2^(5*bits) <= t^5 * 255^11.
   // Byte for an index is the largest b whose entry does not exceed it.
   function automatic thresh_table_type gamma_thresholds(int unsigned bits);
      thresh_table_type tbl;
      big_type          k255;
      big_type          lhs;
      big_type          rhs;
      logic [17:0]      lo;
      logic [17:0]      hi;
      logic [17:0]      mid;
      tbl  = '0;
      k255 = pow_big(big_type'(255), 11);
      for (int b = 1; b < 256; b++) begin
         lhs = pow_big(big_type'(b), 11) << (5 * bits);
         lo  = '0;
         hi  = 18'(1) << bits;
         for (int it = 0; it < 18; it++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               rhs = pow_big(big_type'(mid), 5) * k255;
               if (rhs >= lhs) begin
                  hi = mid;
               end else begin
                  lo = mid + 18'd1;
               end
            end
         end
         tbl[b] = lo[ThreshW-1:0];
      end
      return tbl;
   endfunction

   localparam thresh_table_type GammaThreshDefault = gamma_thresholds(GammaTableBitsDefault);

endpackage

`default_nettype wire

/* sv/hdr_tm_div_cell.sv */
// One restoring-division cell: produces one quotient bit of p*2^16/(2^16+p).
`default_nettype none

module hdr_tm_div_cell
   import hdr_tm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          adv,
   input  wire div_stage_type stage_in,
   output div_stage_type      stage_out
);

   div_stage_type stage_ff;
   logic [32:0]   shifted;
   logic [33:0]   diff;
   logic          ge;
   div_stage_type stage_next_in;

   always_comb begin
      shifted = {stage_in.rem, 1'b0};
      diff    = {1'b0, shifted} - {2'b00, stage_in.dvs};
      ge      = ~diff[33];
      stage_next_in.dvs = stage_in.dvs;
      stage_next_in.quo = {stage_in.quo[14:0], ge};
      // remainder stays below the divisor, so 32 bits hold it
      stage_next_in.rem = ge ? diff[31:0] : shifted[31:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_next_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

/* sv/hdr_tm_gamma_cell.sv */
// One binary-search cell over the gamma thresholds: settles one bit of the output byte.
`default_nettype none

module hdr_tm_gamma_cell
   import hdr_tm_pkg::*;
#(
   parameter int               GAMMA_TABLE_BITS = GammaTableBitsDefault,
   parameter int               STEP             = 0,
   parameter thresh_table_type THRESH           = GammaThreshDefault
) (
   input  wire logic                        clock,
   input  wire logic                        adv,
   input  wire logic [GAMMA_TABLE_BITS-1:0] idx_in,
   input  wire logic [7:0]                  lo_in,
   output logic      [GAMMA_TABLE_BITS-1:0] idx_out,
   output logic      [7:0]                  lo_out
);

   localparam logic [7:0] StepBit = 8'(8'h80 >> STEP);

   logic [GAMMA_TABLE_BITS-1:0] idx_ff;
   logic [7:0]                  lo_ff;
   logic [7:0]                  cand;
   logic [7:0]                  lo_next_in;

   always_comb begin
      cand       = lo_in | StepBit;
      lo_next_in = (THRESH[cand] <= ThreshW'(idx_in)) ? cand : lo_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff <= idx_in;
         lo_ff  <= lo_next_in;
      end
   end

   assign idx_out = idx_ff;
   assign lo_out  = lo_ff;

endmodule

`default_nettype wire

/* sv/hdr_tm_channel.sv */
// One color channel: exposure multiply, saturation, divider cell chain, gamma cell chain.
`default_nettype none

module hdr_tm_channel
   import hdr_tm_pkg::*;
#(
   parameter int               GAMMA_TABLE_BITS = GammaTableBitsDefault,
   parameter thresh_table_type THRESH           = GammaThreshDefault
) (
   input  wire logic               clock,
   input  wire logic               adv,
   input  wire logic signed [31:0] hdr,
   input  wire logic        [23:0] exposure,
   output logic             [7:0]  byte_out
);

   logic [54:0]   prod_ff;
   logic [54:0]   prod_in;
   logic [30:0]   sat_p;
   div_stage_type div_head_ff;
   div_stage_type init_in;
   div_stage_type div_chain [DivSteps+1];

   logic [GAMMA_TABLE_BITS-1:0] gidx [GammaSteps+1];
   logic [7:0]                  glo  [GammaSteps+1];

   // negative radiance maps to zero
   assign prod_in = hdr[31] ? '0 : hdr[30:0] * exposure;

   always_comb begin
      sat_p        = (|prod_ff[54:47]) ? '1 : prod_ff[46:16];
      init_in.rem  = {1'b0, sat_p};
      init_in.dvs  = {1'b0, sat_p} + 32'h0001_0000;
      init_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff     <= prod_in;
         div_head_ff <= init_in;
      end
   end

   assign div_chain[0] = div_head_ff;

   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      hdr_tm_div_cell u_cell (
         .clock     (clock),
         .adv       (adv),
         .stage_in  (div_chain[i]),
         .stage_out (div_chain[i+1])
      );
   end

   assign gidx[0] = div_chain[DivSteps].quo[FracBits-1 -: GAMMA_TABLE_BITS];
   assign glo[0]  = '0;

   for (genvar s = 0; s < GammaSteps; s++) begin : g_gamma
      hdr_tm_gamma_cell #(
         .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS),
         .STEP             (s),
         .THRESH           (THRESH)
      ) u_cell (
         .clock   (clock),
         .adv     (adv),
         .idx_in  (gidx[s]),
         .lo_in   (glo[s]),
         .idx_out (gidx[s+1]),
         .lo_out  (glo[s+1])
      );
   end

   assign byte_out = glo[GammaSteps];

endmodule

`default_nettype wire

/* sv/hdr_tonemap_gamma_to_rgba8_top.sv */
// Top level of the HDR tone mapper: three channel pipelines, valid line and output skid stage.
//
// Takes one texel per clock while req_stall is low and returns one RGBA8 result plus a
// validity byte per texel, in order. The path from an accepted request to rsp_valid runs through
// one multiply stage, one saturation stage, 16 restoring-divider cells for the Reinhard
// fraction and 8 binary-search cells over the gamma thresholds, each one register deep,
// then the output register. A two-entry output stage (output register plus skid) lets a
// request enter while a finished result is held by rsp_stall; req_stall rises only once
// both entries are full. The exposure register must be written only while the pipeline is
// empty.
`default_nettype none

module hdr_tonemap_gamma_to_rgba8_top
   import hdr_tm_pkg::*;
#(
   parameter int GAMMA_TABLE_BITS = GammaTableBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [23:0] csr_wr_data
);

   localparam thresh_table_type GammaThresh = gamma_thresholds(GAMMA_TABLE_BITS);

   logic [23:0]          exposure_ff;
   logic [PipeDepth-1:0] vld_ff;
   logic [PipeDepth-1:0] mask_ff;
   logic                 adv;
   logic [7:0]           red_byte;
   logic [7:0]           green_byte;
   logic [7:0]           blue_byte;
   rsp_type              pipe_rsp;
   rsp_type              out_ff;
   rsp_type              out_in;
   rsp_type              skid_ff;
   rsp_type              skid_in;
   logic                 out_vld_ff;
   logic                 out_vld_in;
   logic                 skid_vld_ff;
   logic                 skid_vld_in;
   logic                 push;
   logic                 pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         exposure_ff <= ExposureReset;
      end else if (csr_wr_en) begin
         exposure_ff <= csr_wr_data;
      end
   end

   // pipeline moves whenever the skid entry is free
   assign adv       = ~skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PipeDepth-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mask_ff <= {mask_ff[PipeDepth-2:0], req_data.texel_valid};
      end
   end

   hdr_tm_channel #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS), .THRESH(GammaThresh)) u_red (
      .clock (clock), .adv (adv), .hdr (req_data.hdr_red),
      .exposure (exposure_ff), .byte_out (red_byte)
   );

   hdr_tm_channel #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS), .THRESH(GammaThresh)) u_green (
      .clock (clock), .adv (adv), .hdr (req_data.hdr_green),
      .exposure (exposure_ff), .byte_out (green_byte)
   );

   hdr_tm_channel #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS), .THRESH(GammaThresh)) u_blue (
      .clock (clock), .adv (adv), .hdr (req_data.hdr_blue),
      .exposure (exposure_ff), .byte_out (blue_byte)
   );

   always_comb begin
      pipe_rsp.out_red   = red_byte;
      pipe_rsp.out_green = green_byte;
      pipe_rsp.out_blue  = blue_byte;
      pipe_rsp.out_alpha = FullByte;
      pipe_rsp.mask_byte = mask_ff[PipeDepth-1] ? FullByte : 8'h00;
   end

   assign push = vld_ff[PipeDepth-1] & adv;
   assign pop  = out_vld_ff & ~rsp_stall;

   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (~out_vld_ff | pop) begin
         out_in     = pipe_rsp;
         out_vld_in = push;
      end else if (push) begin
         skid_in     = pipe_rsp;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry holds a transaction while the output register is empty");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(vld_ff))
      else $error("pipeline advanced while the skid entry was full");

   a_out_drains: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_stall && !skid_vld_ff && !vld_ff[PipeDepth-1]) |=> !out_vld_ff)
      else $error("output register kept a transaction after it was taken");

endmodule

`default_nettype wire
